@@ hw/rtl/snoise_pkg.sv @@
// Shared constants, permutation ROM and helpers for the 2D simplex noise pipeline.
package snoise_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Skew (sqrt(3)-1)/2 and unskew (3-sqrt(3))/6 in fixed point
    localparam logic signed [32:0] SKEW_Q32    = 33'sd1572067139;
    localparam logic signed [31:0] UNSKEW_Q32  = 32'sd907633386;
    localparam logic signed [31:0] UNSKEW_Q28  = 32'sd56727087;
    localparam logic signed [31:0] UNSKEW2_Q28 = 32'sd113454174;
    localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;
    localparam logic [35:0]        HALF_Q28    = 36'd134217728;

    localparam int GRAD_W = 4;

    localparam logic [7:0] HASH_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Gradient index: ROM byte modulo 12, via reciprocal multiply (exact for 8 bits)
    function automatic logic [GRAD_W-1:0] grad_of(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  quo;
        logic [7:0]  rem;
        prod = {8'd0, v} * 16'd171;
        quo  = prod[15:11];
        rem  = v - 8'({3'd0, quo} * 8'd12);
        return rem[GRAD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/snoise_corner.sv @@
// One corner's radial falloff and gradient dot product, five register stages.
module snoise_corner (
    input  logic                                i_clk,
    input  logic [4:0]                          i_en,
    input  logic signed [31:0]                  i_dx,
    input  logic signed [31:0]                  i_dy,
    input  logic [snoise_pkg::GRAD_W-1:0]       i_grad,
    output logic signed [31:0]                  o_term
);

    logic [62:0]        r_sqx;
    logic [62:0]        r_sqy;
    logic signed [33:0] r_d0;
    logic [27:0]        r_t;
    logic               r_ok1;
    logic signed [33:0] r_d1;
    logic [26:0]        r_t2;
    logic               r_ok2;
    logic signed [33:0] r_d2;
    logic [24:0]        r_t4;
    logic               r_ok3;
    logic signed [33:0] r_d3;
    logic signed [31:0] r_term;

    logic signed [63:0] sqx;
    logic signed [63:0] sqy;
    logic signed [33:0] dxe;
    logic signed [33:0] dye;
    logic signed [33:0] gxd;
    logic signed [33:0] gyd;
    logic [63:0]        r2sum;
    logic [35:0]        r2;
    logic [35:0]        t_d;
    logic [55:0]        tt;
    logic [53:0]        t2t2;
    logic signed [59:0] prod;

    // Gradient directions: x and y components in {-1, 0, +1}
    always_comb begin
        sqx = i_dx * i_dx;
        sqy = i_dy * i_dy;
        dxe = {{2{i_dx[31]}}, i_dx};
        dye = {{2{i_dy[31]}}, i_dy};
        gxd = '0;
        gyd = '0;
        case (i_grad) inside
            4'd0, 4'd2, 4'd4, 4'd6: gxd = dxe;
            4'd1, 4'd3, 4'd5, 4'd7: gxd = -dxe;
            default:                gxd = '0;
        endcase
        case (i_grad) inside
            4'd0, 4'd1, 4'd8, 4'd10: gyd = dye;
            4'd2, 4'd3, 4'd9, 4'd11: gyd = -dye;
            default:                 gyd = '0;
        endcase
    end

    always_comb begin
        r2sum = {1'b0, r_sqx} + {1'b0, r_sqy};
        r2    = r2sum[63:28];
        t_d   = snoise_pkg::HALF_Q28 - r2;
        tt    = r_t * r_t;
        t2t2  = r_t2 * r_t2;
        prod  = $signed({1'b0, r_t4}) * r_d3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sqx <= sqx[62:0];
            r_sqy <= sqy[62:0];
            r_d0  <= gxd + gyd;
        end
        if (i_en[1]) begin
            r_ok1 <= (r2 <= snoise_pkg::HALF_Q28);
            r_t   <= t_d[27:0];
            r_d1  <= r_d0;
        end
        if (i_en[2]) begin
            r_t2  <= tt[54:28];
            r_ok2 <= r_ok1;
            r_d2  <= r_d1;
        end
        if (i_en[3]) begin
            r_t4  <= t2t2[52:28];
            r_ok3 <= r_ok2;
            r_d3  <= r_d2;
        end
        if (i_en[4]) begin
            r_term <= r_ok3 ? prod[59:28] : '0;
        end
    end

    assign o_term = r_term;

endmodule

@@ hw/rtl/simplex_noise_2d.sv @@
// Top level of the pipelined 2D simplex noise evaluator.
//
// Usage: present a point (i_x_coord, i_y_coord, signed fixed point with
// FRAC_BITS fraction bits) and an 8-bit i_seed with i_valid; a transaction
// completes when i_valid and o_ready are both high. Each input transaction
// yields exactly one output transaction carrying o_noise_value, unsigned
// Q0.16 noise saturated to [0, 65535], handed off on o_valid / i_ready.
//
// Throughput: one point per clock while i_ready is high. An input point
// reaches o_valid through the twelve register stages (skew multiply, cell
// floor, unskew multiply, corner offsets plus first ROM lookup, second ROM
// lookup, five stages of per-corner falloff products, the corner sum and the
// final scale/saturate).
//
// Each stage holds its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles collapse and the pipe keeps taking
// points while a finished result waits. When the receiver stalls, stages
// fill up and o_ready drops only once every stage holds a point; nothing is
// dropped or repeated. Reset clears all valid bits; the datapath needs none.
module simplex_noise_2d #(
    parameter int FRAC_BITS = snoise_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic [7:0]         i_seed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_noise_value
);

    localparam int NS = 12;             // pipeline depth
    localparam int CW = 34 - FRAC_BITS; // cell index width
    localparam int CORNER_FIRST = 5;    // first stage inside the corner units

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    // Stage 0: skew product
    logic signed [31:0] r_s0_x, r_s0_y, r_s0_skew;
    logic [7:0]         r_s0_seed;
    // Stage 1: cell indices
    logic signed [CW-1:0] r_s1_ci, r_s1_cj;
    logic signed [31:0]   r_s1_x, r_s1_y;
    logic [7:0]           r_s1_seed;
    // Stage 2: unskew term and local offsets, 32 fraction bits, mod 2^36
    logic [35:0] r_s2_tw, r_s2_ax, r_s2_ay;
    logic [7:0]  r_s2_hi, r_s2_hj, r_s2_seed;
    // Stage 3: first corner offsets and inner hashes
    logic signed [31:0] r_s3_x0, r_s3_y0;
    logic [7:0]         r_s3_hi, r_s3_seed, r_s3_inner0, r_s3_inner1;
    // Stage 4: all corner offsets and gradient codes
    logic signed [31:0]           r_s4_dx [3];
    logic signed [31:0]           r_s4_dy [3];
    logic [snoise_pkg::GRAD_W-1:0] r_s4_g [3];
    // Stage 10/11: sum and output
    logic signed [33:0] r_s10_sum;
    logic [15:0]        r_out;

    logic signed [31:0] term [3];

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: s = floor((x + y) * skew) ----------------
    logic signed [32:0] xy_sum;
    logic signed [65:0] skew_prod;
    always_comb begin
        xy_sum    = {i_x_coord[31], i_x_coord} + {i_y_coord[31], i_y_coord};
        skew_prod = xy_sum * snoise_pkg::SKEW_Q32;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_x    <= i_x_coord;
            r_s0_y    <= i_y_coord;
            r_s0_seed <= i_seed;
            r_s0_skew <= skew_prod[63:32];
        end
    end

    // ---------------- stage 1: true floor of the skewed point ----------------
    logic signed [33:0] xs, ys;
    always_comb begin
        xs = {{2{r_s0_x[31]}}, r_s0_x} + {{2{r_s0_skew[31]}}, r_s0_skew};
        ys = {{2{r_s0_y[31]}}, r_s0_y} + {{2{r_s0_skew[31]}}, r_s0_skew};
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_ci   <= xs[33:FRAC_BITS];
            r_s1_cj   <= ys[33:FRAC_BITS];
            r_s1_x    <= r_s0_x;
            r_s1_y    <= r_s0_y;
            r_s1_seed <= r_s0_seed;
        end
    end

    // ---------------- stage 2: unskew term and cell-relative coords ----------
    // Offsets end up small, so only the low 36 bits of each partial are kept.
    logic signed [CW:0]    cell_sum;
    logic signed [CW+32:0] tw_full;
    logic [35:0]           dx_raw, dy_raw;
    always_comb begin
        cell_sum = {r_s1_ci[CW-1], r_s1_ci} + {r_s1_cj[CW-1], r_s1_cj};
        tw_full  = cell_sum * snoise_pkg::UNSKEW_Q32;
        dx_raw   = {{4{r_s1_x[31]}}, r_s1_x}
                 - ({{(36-CW){r_s1_ci[CW-1]}}, r_s1_ci} << FRAC_BITS);
        dy_raw   = {{4{r_s1_y[31]}}, r_s1_y}
                 - ({{(36-CW){r_s1_cj[CW-1]}}, r_s1_cj} << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_tw   <= tw_full[35:0];
            r_s2_ax   <= dx_raw << (32 - FRAC_BITS);
            r_s2_ay   <= dy_raw << (32 - FRAC_BITS);
            r_s2_hi   <= r_s1_ci[7:0];
            r_s2_hj   <= r_s1_cj[7:0];
            r_s2_seed <= r_s1_seed;
        end
    end

    // ---------------- stage 3: corner 0 offsets, inner hash lookups ----------
    logic [35:0] x0_wide, y0_wide;
    logic [7:0]  idx_in0, idx_in1;
    always_comb begin
        x0_wide = r_s2_ax + r_s2_tw;
        y0_wide = r_s2_ay + r_s2_tw;
        idx_in0 = r_s2_seed + r_s2_hj;
        idx_in1 = r_s2_seed + r_s2_hj + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_x0     <= x0_wide[35:4];
            r_s3_y0     <= y0_wide[35:4];
            r_s3_hi     <= r_s2_hi;
            r_s3_seed   <= r_s2_seed;
            r_s3_inner0 <= snoise_pkg::HASH_ROM[idx_in0];
            r_s3_inner1 <= snoise_pkg::HASH_ROM[idx_in1];
        end
    end

    // ---------------- stage 4: triangle pick, offsets, gradient codes --------
    // A tie between the x and y offsets takes the upper triangle.
    logic                          lower;
    logic signed [31:0]            x1, y1, x2, y2;
    logic [7:0]                    idx_a, idx_b, idx_c, idx_d;
    logic [snoise_pkg::GRAD_W-1:0] g_a, g_b, g_c, g_d;
    always_comb begin
        lower = r_s3_x0 > r_s3_y0;
        x1    = r_s3_x0 - (lower ? snoise_pkg::ONE_Q28 : 32'sd0) + snoise_pkg::UNSKEW_Q28;
        y1    = r_s3_y0 - (lower ? 32'sd0 : snoise_pkg::ONE_Q28) + snoise_pkg::UNSKEW_Q28;
        x2    = r_s3_x0 - snoise_pkg::ONE_Q28 + snoise_pkg::UNSKEW2_Q28;
        y2    = r_s3_y0 - snoise_pkg::ONE_Q28 + snoise_pkg::UNSKEW2_Q28;
        idx_a = r_s3_seed + r_s3_hi + r_s3_inner0;
        idx_b = r_s3_seed + r_s3_hi + 8'd1 + r_s3_inner0;
        idx_c = r_s3_seed + r_s3_hi + r_s3_inner1;
        idx_d = r_s3_seed + r_s3_hi + 8'd1 + r_s3_inner1;
        g_a   = snoise_pkg::grad_of(snoise_pkg::HASH_ROM[idx_a]);
        g_b   = snoise_pkg::grad_of(snoise_pkg::HASH_ROM[idx_b]);
        g_c   = snoise_pkg::grad_of(snoise_pkg::HASH_ROM[idx_c]);
        g_d   = snoise_pkg::grad_of(snoise_pkg::HASH_ROM[idx_d]);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_dx[0] <= r_s3_x0;
            r_s4_dy[0] <= r_s3_y0;
            r_s4_dx[1] <= x1;
            r_s4_dy[1] <= y1;
            r_s4_dx[2] <= x2;
            r_s4_dy[2] <= y2;
            r_s4_g[0]  <= g_a;
            r_s4_g[1]  <= lower ? g_b : g_c;
            r_s4_g[2]  <= g_d;
        end
    end

    // ---------------- stages 5..9: per-corner falloff and dot product --------
    for (genvar c = 0; c < 3; c++) begin : g_corner
        snoise_corner u_corner (
            .i_clk  (i_clk),
            .i_en   (en[CORNER_FIRST+4:CORNER_FIRST]),
            .i_dx   (r_s4_dx[c]),
            .i_dy   (r_s4_dy[c]),
            .i_grad (r_s4_g[c]),
            .o_term (term[c])
        );
    end

    // ---------------- stage 10: corner sum ----------------
    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_s10_sum <= {{2{term[0][31]}}, term[0]} + {{2{term[1][31]}}, term[1]}
                       + {{2{term[2][31]}}, term[2]};
        end
    end

    // ---------------- stage 11: scale by 35, add one half, saturate ----------
    logic signed [40:0] scaled;
    logic signed [28:0] v_q16;
    logic [15:0]        v_sat;
    always_comb begin
        scaled = {{7{r_s10_sum[33]}}, r_s10_sum} * 41'sd35
               + $signed({5'd0, snoise_pkg::HALF_Q28});
        v_q16  = scaled[40:12];
        if (v_q16 < 29'sd0) begin
            v_sat = 16'd0;
        end else if (v_q16 > 29'sd65535) begin
            v_sat = 16'hFFFF;
        end else begin
            v_sat = v_q16[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_out <= v_sat;
        end
    end

    assign o_ready       = en[0];
    assign o_valid       = r_vld[NS-1];
    assign o_noise_value = r_out;

endmodule
